// ----- rtl/skit_pkg.sv -----
// package: shared constants and types for the sorted key interpolation table
package skit_pkg;
  localparam int unsigned CapacityDefault   = 64;
  localparam int unsigned ObjectBitsDefault = 64;
  localparam int unsigned KeyBits           = 32;
  localparam int unsigned PayloadBits       = 64;
  localparam int unsigned FracBits          = 17;
  localparam int unsigned CountBits         = 7;
  localparam int unsigned StatusBits        = 2;
  localparam logic [FracBits-1:0] FractionOne = 17'h10000;

  typedef enum logic [StatusBits-1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OpNone,
    OpStart,
    OpRead,
    OpLoad,
    OpWrite,
    OpDivInit,
    OpDivStep,
    OpCapture
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   use_prev;
    logic   dec_idx;
    logic   inc_idx;
    logic   write_new;
    logic   inc_count;
    logic   res_frac_one;
    logic   res_objs;
    logic   res_div;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_zero;
    logic idx_end;
    logic key_neg;
    logic rd_gt;
    logic q_lt_rd;
    logic div_done;
    logic kind;
  } dp_stat_t;
endpackage

// ----- rtl/skit_ram.sv -----
// generic ram with one write port and one registered read port
module skit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/skit_datapath.sv -----
// datapath: key and object memories, index counter, serial divider, result registers
module skit_datapath #(
  parameter int unsigned Capacity   = 64,
  parameter int unsigned ObjectBits = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_take_i,
  input  logic                               in_kind_i,
  input  logic signed [skit_pkg::KeyBits-1:0] in_key_i,
  input  logic [skit_pkg::PayloadBits-1:0]   in_payload_i,
  input  skit_pkg::dp_cmd_t                  cmd_i,
  output skit_pkg::dp_stat_t                 stat_o,
  output logic [skit_pkg::FracBits-1:0]      fraction_o,
  output logic [skit_pkg::PayloadBits-1:0]   lower_object_o,
  output logic [skit_pkg::PayloadBits-1:0]   upper_object_o,
  output logic [skit_pkg::CountBits-1:0]     entry_count_o,
  output logic [skit_pkg::StatusBits-1:0]    status_o
);
  import skit_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned DW = KeyBits + 1;
  localparam int unsigned NW = DW + 16;
  localparam int unsigned DivSteps = NW;

  logic kind_q;
  logic signed [KeyBits-1:0] key_q;
  logic [ObjectBits-1:0] obj_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic signed [KeyBits-1:0] rd_key, wkey;
  logic [ObjectBits-1:0] rd_obj, wobj;
  logic signed [KeyBits-1:0] cur_key_q, lo_key_q;
  logic [ObjectBits-1:0] cur_obj_q, lo_obj_q;
  logic [NW-1:0] quo_q;
  logic [DW:0] rem_q;
  logic [DW-1:0] den_q;
  logic [$clog2(DivSteps+1)-1:0] dcnt_q;
  logic [FracBits-1:0] frac_q;
  logic [ObjectBits-1:0] lobj_q, uobj_q;
  logic [StatusBits-1:0] stat_q;
  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;

  assign raddr = cmd_i.use_prev ? AW'(idx_q - CW'(1)) : AW'(idx_q);
  assign waddr = AW'(idx_q);
  assign we    = cmd_i.op == OpWrite;
  assign wkey  = cmd_i.write_new ? key_q : cur_key_q;
  assign wobj  = cmd_i.write_new ? obj_q : cur_obj_q;

  skit_ram #(.Width(KeyBits), .Depth(Capacity)) u_keys (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wkey), .raddr_i(raddr),
    .rdata_o(rd_key)
  );
  skit_ram #(.Width(ObjectBits), .Depth(Capacity)) u_objs (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wobj), .raddr_i(raddr),
    .rdata_o(rd_obj)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.inc_count) count_d = count_q + CW'(1);
    idx_d = idx_q;
    if (cmd_i.op == OpStart) idx_d = kind_q ? '0 : count_q;
    else if (cmd_i.dec_idx) idx_d = idx_q - CW'(1);
    else if (cmd_i.inc_idx) idx_d = idx_q + CW'(1);
  end

  assign rem_sh  = {rem_q[DW-1:0], quo_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.op == OpDivInit) dcnt_q <= '0;
      else if (cmd_i.op == OpDivStep) dcnt_q <= dcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      kind_q <= in_kind_i;
      key_q  <= in_key_i;
      obj_q  <= in_payload_i[ObjectBits-1:0];
    end
    if (cmd_i.op == OpStart) begin
      lo_key_q <= '0;
    end
    if (cmd_i.op == OpLoad) begin
      if (kind_q && idx_q != '0) begin
        lo_key_q <= cur_key_q;
        lo_obj_q <= cur_obj_q;
      end else if (kind_q) begin
        lo_obj_q <= rd_obj;
      end
      cur_key_q <= rd_key;
      cur_obj_q <= rd_obj;
    end
    if (cmd_i.op == OpDivInit) begin
      quo_q <= {DW'($signed({key_q[KeyBits-1], key_q}) -
                    $signed({lo_key_q[KeyBits-1], lo_key_q})), 16'h0};
      den_q <= DW'($signed({cur_key_q[KeyBits-1], cur_key_q}) -
                   $signed({lo_key_q[KeyBits-1], lo_key_q}));
      rem_q <= '0;
    end
    if (cmd_i.op == OpDivStep) begin
      if (!rem_sub[DW]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
    if (cmd_i.op == OpCapture) begin
      stat_q <= cmd_i.status;
      if (cmd_i.res_div) begin
        frac_q <= (quo_q > NW'(FractionOne)) ? FractionOne : quo_q[FracBits-1:0];
      end else if (cmd_i.res_frac_one) begin
        frac_q <= FractionOne;
      end else begin
        frac_q <= '0;
      end
      if (cmd_i.res_objs) begin
        lobj_q <= cmd_i.res_div ? lo_obj_q : cur_obj_q;
        uobj_q <= cur_obj_q;
      end else begin
        lobj_q <= '0;
        uobj_q <= '0;
      end
    end
  end

  assign stat_o.count_zero = count_q == '0;
  assign stat_o.full       = count_q >= CW'(Capacity);
  assign stat_o.idx_zero   = idx_q == '0;
  assign stat_o.idx_end    = idx_q >= count_q;
  assign stat_o.key_neg    = key_q[KeyBits-1];
  assign stat_o.rd_gt      = rd_key > key_q;
  assign stat_o.q_lt_rd    = key_q < rd_key;
  assign stat_o.div_done   = dcnt_q == $bits(dcnt_q)'(DivSteps);
  assign stat_o.kind       = kind_q;

  assign fraction_o     = frac_q;
  assign lower_object_o = PayloadBits'(lobj_q);
  assign upper_object_o = PayloadBits'(uobj_q);
  assign entry_count_o  = CountBits'(count_q);
  assign status_o       = stat_q;
endmodule

// ----- rtl/skit_ctrl.sv -----
// controller: sequences insert shifts, evaluate scans and the divider
module skit_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  skit_pkg::dp_stat_t stat_i,
  output skit_pkg::dp_cmd_t  cmd_o
);
  import skit_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StStart, StInsRead, StInsCmp, StEvRead, StEvCmp,
    StDivInit, StDiv, StLastRead, StLastLoad, StDone, StOut
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q;

  assign in_ready_o  = state_q == StIdle && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.op = OpNone;
    cmd_o.status = StatusOk;
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i && in_ready_o) state_d = StStart;
      StStart: begin
        if (!stat_i.kind) begin
          if (stat_i.full) begin
            cmd_o.op = OpCapture; cmd_o.status = StatusFull; state_d = StOut;
          end else begin
            cmd_o.op = OpStart; state_d = StInsRead;
          end
        end else if (stat_i.count_zero) begin
          cmd_o.op = OpCapture; cmd_o.status = StatusEmpty; state_d = StOut;
        end else begin
          cmd_o.op = OpStart; state_d = StEvRead;
        end
      end
      StInsRead: begin
        if (stat_i.idx_zero) begin
          cmd_o.op = OpWrite; cmd_o.write_new = 1'b1; cmd_o.inc_count = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.use_prev = 1'b1; state_d = StInsCmp;
        end
      end
      StInsCmp: begin
        if (stat_i.rd_gt) begin
          cmd_o.op = OpLoad; state_d = StDone;
        end else begin
          cmd_o.op = OpWrite; cmd_o.write_new = 1'b1; cmd_o.inc_count = 1'b1;
          state_d = StDone;
        end
        if (stat_i.rd_gt) state_d = StLastLoad;
      end
      StLastLoad: begin
        cmd_o.op = OpWrite; cmd_o.dec_idx = 1'b1; state_d = StInsRead;
      end
      StEvRead: begin
        if (stat_i.key_neg) begin
          state_d = StLastRead;
        end else if (stat_i.idx_end) begin
          state_d = StDone;
        end else begin
          state_d = StEvCmp;
        end
      end
      StEvCmp: begin
        cmd_o.op = OpLoad; cmd_o.inc_idx = 1'b1;
        state_d = stat_i.q_lt_rd ? StDivInit : StEvRead;
      end
      StDivInit: begin
        cmd_o.op = OpDivInit; state_d = StDiv;
      end
      StDiv: begin
        if (stat_i.div_done) begin
          cmd_o.op = OpCapture; cmd_o.res_div = 1'b1; cmd_o.res_objs = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.op = OpDivStep;
        end
      end
      StLastRead: begin
        cmd_o.op = OpLoad; state_d = StDone;
      end
      StDone: begin
        cmd_o.op = OpCapture;
        if (stat_i.kind) begin
          cmd_o.res_objs = 1'b1;
          cmd_o.res_frac_one = !stat_i.key_neg;
        end
        state_d = StOut;
      end
      StOut: if (!out_valid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && !out_valid_q) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_take_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == StStart) else $error("no start");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
`endif
endmodule

// ----- rtl/sorted_key_interpolation_table.sv -----
// top level: sorted key interpolation table
// Channels: one request channel (in_valid_i/in_ready_o with kind, key,
// payload) and one result channel (out_valid_o/out_ready_i).
// kind 0 inserts (key, payload) after all entries with key <= the new key;
// kind 1 evaluates the query key and returns the Q1.16 fraction and the
// lower and upper objects of the segment, with entry_count and status.
// One request is in flight at a time; one result per request.
// Insert moves each entry with a larger key up one place; each move runs
// the states InsRead, InsCmp and LastLoad to read the entry and write it back.
// Evaluate scans the segments with the states EvRead and EvCmp, and when
// the query falls inside a segment it runs the bit serial divider:
// load, 49 quotient bits at one per cycle, capture.
// The result stays in the output register until taken; a new request is
// accepted only after the result is taken, so a stalled receiver stalls the
// block. Reset empties the table (entry_count 0) and needs no clearing pass.
module sorted_key_interpolation_table #(
  parameter int unsigned Capacity   = skit_pkg::CapacityDefault,
  parameter int unsigned ObjectBits = skit_pkg::ObjectBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic signed [skit_pkg::KeyBits-1:0] key_i,
  input  logic [skit_pkg::PayloadBits-1:0]   payload_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [skit_pkg::FracBits-1:0]      fraction_o,
  output logic [skit_pkg::PayloadBits-1:0]   lower_object_o,
  output logic [skit_pkg::PayloadBits-1:0]   upper_object_o,
  output logic [skit_pkg::CountBits-1:0]     entry_count_o,
  output logic [skit_pkg::StatusBits-1:0]    status_o
);
  import skit_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skit_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  skit_datapath #(.Capacity(Capacity), .ObjectBits(ObjectBits)) u_dp (
    .clk_i, .rst_ni, .in_take_i(in_valid_i && in_ready_o), .in_kind_i(kind_i),
    .in_key_i(key_i), .in_payload_i(payload_i), .cmd_i(cmd), .stat_o(stat),
    .fraction_o, .lower_object_o, .upper_object_o, .entry_count_o, .status_o
  );
endmodule
